// File: hdl/gsf_pkg.sv
// Package for the gaussian splat frame buffer: frame geometry, field widths,
// request codes, stage structs and the divide-by-255 helper. No dependencies.
`timescale 1ns / 1ps
package gsf_pkg;

  localparam int FRAME_WIDTH   = 512;
  localparam int FRAME_HEIGHT  = 512;
  localparam int MAX_THICKNESS = 3;
  localparam int FALLOFF_DEPTH = 256;

  localparam int NPIX    = FRAME_WIDTH * FRAME_HEIGHT;
  localparam int ADDR_W  = $clog2(NPIX);
  localparam int COL_W   = $clog2(FRAME_WIDTH);
  localparam int ROW_W   = $clog2(FRAME_HEIGHT);
  localparam int TBL_AW  = $clog2(FALLOFF_DEPTH);
  localparam int CLR_LEN = (NPIX > FALLOFF_DEPTH) ? NPIX : FALLOFF_DEPTH;
  localparam int CLR_W   = $clog2(CLR_LEN);

  // Q4 position, window coordinates, window offsets and distance widths
  localparam int MAX_DIM = (FRAME_WIDTH > FRAME_HEIGHT) ? FRAME_WIDTH : FRAME_HEIGHT;
  localparam int POS_W   = $clog2(MAX_DIM * 8 + 16384) + 1;
  localparam int C_W     = POS_W - 2;
  localparam int OFS_W   = $clog2(2 * MAX_THICKNESS + 2);
  localparam int T_W     = $clog2(MAX_THICKNESS + 2);
  localparam int DX_W    = $clog2(16 * MAX_THICKNESS + 9) + 1;
  localparam int D2_W    = 2 * DX_W;

  // port field widths
  localparam int KIND_W  = 2;
  localparam int XY_W    = 15;
  localparam int CH_W    = 8;
  localparam int RC_W    = 9;
  localparam int TIDX_W  = 8;
  localparam int TVAL_W  = 9;
  localparam int CNT_W   = 6;
  localparam int CFG_W   = 4;
  localparam int CFGI_W  = 1;
  localparam int THK_W   = 2;
  localparam int DSH_W   = 4;

  localparam logic [KIND_W-1:0] REQ_SPLAT = 2'd0;
  localparam logic [KIND_W-1:0] REQ_READ  = 2'd1;
  localparam logic [KIND_W-1:0] REQ_LOAD  = 2'd2;

  localparam logic [CFGI_W-1:0] REG_LINE_THICKNESS = 1'd0;
  localparam logic [CFGI_W-1:0] REG_DIST_SHIFT     = 1'd1;

  localparam logic [31:0] BASE_INIT = 32'hFF00_0000;
  localparam logic [TVAL_W-1:0] FULL_FACTOR = 9'd256;

  // reciprocal of 255 in Q23, always rounds up by at most one
  localparam logic [15:0] DIV_MUL = 16'd32897;
  localparam int DIV_SHIFT = 23;

  typedef struct packed {
    logic              valid;
    logic              rd;
    logic [ADDR_W-1:0] addr;
    logic [31:0]       dst;
    logic [23:0]       src;
    logic [7:0]        sa;
  } blend_in_t;

  typedef struct packed {
    logic              valid;
    logic              rd;
    logic [ADDR_W-1:0] addr;
    logic [31:0]       pix;
  } blend_out_t;

  function automatic logic [7:0] div255(input logic [16:0] x);
    logic [33:0] m;
    logic [10:0] q;
    m = 34'(x) * 34'(DIV_MUL);
    q = m[33:DIV_SHIFT];
    if ((19'(q) * 19'(255)) > 19'(x)) begin
      q = q - 11'd1;
    end
    return q[7:0];
  endfunction

endpackage

// File: hdl/gaussian_splat_framebuffer.sv
// Top level of the gaussian splat frame buffer: request control, window walk,
// falloff lookup and frame store access. Depends on gsf_pkg, gsf_ram, gsf_blend.
//
//   channel | ports                         | moves
//   in      | in_valid / in_stall + fields  | one request per transfer
//   out     | out_valid / out_stall + fields| one result per request
//   cfg     | cfg_we, cfg_index, cfg_data   | register write, no wait
//
// A splat walks the (2*t+1)^2 window (t = clamped thickness, 1 at reset value):
// one window pixel per cycle; each in-frame pixel enters the read-blend-write pipe,
// which reads both frame stores and writes one. A readout on the frame also uses the
// pipe; other requests go straight to the result. After reset a clearing pass
// initializes both frame stores and the falloff table; in_stall stays high during it.
// A new request is taken while a finished result still waits on out_stall.
`timescale 1ns / 1ps
module gaussian_splat_framebuffer (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [gsf_pkg::CFGI_W-1:0]   cfg_index,
  input  logic [gsf_pkg::CFG_W-1:0]    cfg_data,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [gsf_pkg::KIND_W-1:0]   in_req_type,
  input  logic signed [gsf_pkg::XY_W-1:0] in_x,
  input  logic signed [gsf_pkg::XY_W-1:0] in_y,
  input  logic [gsf_pkg::CH_W-1:0]     in_red,
  input  logic [gsf_pkg::CH_W-1:0]     in_green,
  input  logic [gsf_pkg::CH_W-1:0]     in_blue,
  input  logic [gsf_pkg::CH_W-1:0]     in_alpha,
  input  logic                         in_layer,
  input  logic [gsf_pkg::RC_W-1:0]     in_row,
  input  logic [gsf_pkg::RC_W-1:0]     in_col,
  input  logic [gsf_pkg::TIDX_W-1:0]   in_table_index,
  input  logic [gsf_pkg::TVAL_W-1:0]   in_table_value,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [gsf_pkg::KIND_W-1:0]   out_done_kind,
  output logic [gsf_pkg::CH_W-1:0]     out_red,
  output logic [gsf_pkg::CH_W-1:0]     out_green,
  output logic [gsf_pkg::CH_W-1:0]     out_blue,
  output logic [gsf_pkg::CNT_W-1:0]    out_pixels_touched
);
  import gsf_pkg::*;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_WALK  = 3'd2;
  localparam logic [2:0] ST_DRAIN = 3'd3;
  localparam logic [2:0] ST_FIN   = 3'd4;

  logic [2:0]       state_r, state_nxt;
  logic [CLR_W-1:0] clr_r;
  logic [THK_W-1:0] thick_r;
  logic [DSH_W-1:0] dshift_r;

  // request context
  logic [KIND_W-1:0]     kind_r;
  logic [CH_W-1:0]       red_r, green_r, blue_r, alpha_r;
  logic                  layer_r;
  logic [T_W-1:0]        t_r;
  logic [OFS_W-1:0]      span_r, ox_r, oy_r;
  logic signed [C_W-1:0] i0_r, j0_r;
  logic [3:0]            pxlo_r, pylo_r;
  logic [CNT_W-1:0]      touched_r;
  logic [CH_W-1:0]       res_r_r, res_g_r, res_b_r;

  // pipe stages
  logic                   v1_r, v2_r, v3_r;
  logic                   rd2_r, rd3_r;
  logic [ADDR_W-1:0]      addr1_r, addr2_r, addr3_r;
  logic signed [DX_W-1:0] dx1_r, dy1_r;
  logic [7:0]             sa3_r;

  // comb
  logic                   accept, clr_act;
  logic [T_W-1:0]         tc;
  logic signed [POS_W-1:0] px_c, py_c;
  logic signed [C_W-1:0]  i_c, j_c;
  logic                   inframe_c, last_c, rd_in_frame, pipe_empty;
  logic signed [DX_W-1:0] kx, ky, dx_c, dy_c;
  logic [ADDR_W-1:0]      addr_c, rd_addr;
  logic signed [D2_W-1:0] sqx, sqy;
  logic [D2_W-1:0]        d2, d2s;
  logic [TBL_AW-1:0]      idx_c;
  logic [TVAL_W-1:0]      tbl_q, fac;
  logic [16:0]            sa_prod;
  logic [31:0]            base_q, ovl_q;
  blend_in_t              bin;
  blend_out_t             bout;

  logic               base_we, ovl_we, tbl_we;
  logic [ADDR_W-1:0]  base_wa, ovl_wa;
  logic [31:0]        base_wd, ovl_wd;
  logic [TBL_AW-1:0]  tbl_wa;
  logic [TVAL_W-1:0]  tbl_wd;

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign clr_act  = (state_r == ST_CLEAR);

  assign tc   = (32'(thick_r) > 32'(MAX_THICKNESS)) ? T_W'(MAX_THICKNESS) : T_W'(thick_r);
  assign px_c = POS_W'(FRAME_WIDTH * 8) + POS_W'(in_x);
  assign py_c = POS_W'(FRAME_HEIGHT * 8) - POS_W'(in_y);

  assign rd_in_frame = (32'(in_row) < 32'(FRAME_HEIGHT)) && (32'(in_col) < 32'(FRAME_WIDTH));
  assign rd_addr = ADDR_W'(32'(in_row) * 32'(FRAME_WIDTH) + 32'(in_col));

  // window walk: current pixel, in-frame test, offset from the point
  assign i_c = i0_r + C_W'(ox_r);
  assign j_c = j0_r + C_W'(oy_r);
  assign inframe_c = !i_c[C_W-1] && (i_c[C_W-2:0] < (C_W-1)'(FRAME_WIDTH)) &&
                     !j_c[C_W-1] && (j_c[C_W-2:0] < (C_W-1)'(FRAME_HEIGHT));
  assign kx   = DX_W'(ox_r) - DX_W'(t_r);
  assign ky   = DX_W'(oy_r) - DX_W'(t_r);
  assign dx_c = DX_W'(pxlo_r) - DX_W'(8) - (kx <<< 4);
  assign dy_c = DX_W'(pylo_r) - DX_W'(8) - (ky <<< 4);
  assign addr_c = ADDR_W'(32'(j_c[ROW_W-1:0]) * 32'(FRAME_WIDTH) + 32'(i_c[COL_W-1:0]));
  assign last_c = (ox_r == span_r) && (oy_r == span_r);

  // squared distance to table index
  assign sqx = dx1_r * dx1_r;
  assign sqy = dy1_r * dy1_r;
  assign d2  = D2_W'(sqx) + D2_W'(sqy);
  assign d2s = d2 >> dshift_r;
  assign idx_c = (32'(d2s) >= 32'(FALLOFF_DEPTH)) ? TBL_AW'(FALLOFF_DEPTH - 1) : TBL_AW'(d2s);

  assign fac     = (tbl_q > FULL_FACTOR) ? FULL_FACTOR : tbl_q;
  assign sa_prod = 17'(alpha_r) * 17'(fac);

  assign pipe_empty = !v1_r && !v2_r && !v3_r && !bout.valid;

  always_comb begin
    bin.valid = v3_r;
    bin.rd    = rd3_r;
    bin.addr  = addr3_r;
    if (rd3_r) begin
      bin.dst = base_q;
      bin.src = ovl_q[23:0];
      bin.sa  = ovl_q[31:24];
    end else begin
      bin.dst = layer_r ? base_q : ovl_q;
      bin.src = {blue_r, green_r, red_r};
      bin.sa  = sa3_r;
    end
  end

  // store write ports: clearing pass, else writeback
  always_comb begin
    if (clr_act) begin
      base_we = (32'(clr_r) < 32'(NPIX));
      base_wa = ADDR_W'(clr_r);
      base_wd = BASE_INIT;
      ovl_we  = base_we;
      ovl_wa  = ADDR_W'(clr_r);
      ovl_wd  = 32'd0;
      tbl_we  = (32'(clr_r) < 32'(FALLOFF_DEPTH));
      tbl_wa  = TBL_AW'(clr_r);
      tbl_wd  = '0;
    end else begin
      base_we = bout.valid && !bout.rd && layer_r;
      base_wa = bout.addr;
      base_wd = bout.pix;
      ovl_we  = bout.valid && (bout.rd || !layer_r);
      ovl_wa  = bout.addr;
      ovl_wd  = bout.rd ? 32'd0 : bout.pix;
      tbl_we  = accept && (in_req_type == REQ_LOAD) &&
                (32'(in_table_index) < 32'(FALLOFF_DEPTH));
      tbl_wa  = TBL_AW'(in_table_index);
      tbl_wd  = in_table_value;
    end
  end

  gsf_ram #(.DATA_W(32), .DEPTH(NPIX)) u_base (
    .clk(clk), .we(base_we), .waddr(base_wa), .wdata(base_wd),
    .raddr(addr2_r), .rdata(base_q)
  );

  gsf_ram #(.DATA_W(32), .DEPTH(NPIX)) u_ovl (
    .clk(clk), .we(ovl_we), .waddr(ovl_wa), .wdata(ovl_wd),
    .raddr(addr2_r), .rdata(ovl_q)
  );

  gsf_ram #(.DATA_W(TVAL_W), .DEPTH(FALLOFF_DEPTH)) u_tbl (
    .clk(clk), .we(tbl_we), .waddr(tbl_wa), .wdata(tbl_wd),
    .raddr(idx_c), .rdata(tbl_q)
  );

  gsf_blend u_blend (
    .clk(clk), .rst_n(rst_n), .bin(bin), .bout(bout)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (clr_r == CLR_W'(CLR_LEN - 1)) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          if (in_req_type == REQ_SPLAT) state_nxt = ST_WALK;
          else if (in_req_type == REQ_READ && rd_in_frame) state_nxt = ST_DRAIN;
          else state_nxt = ST_FIN;
        end
      end
      ST_WALK: begin
        if (last_c) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (pipe_empty) state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (!out_valid || !out_stall) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      clr_r     <= '0;
      thick_r   <= THK_W'(1);
      dshift_r  <= DSH_W'(5);
      out_valid <= 1'b0;
      v1_r      <= 1'b0;
      v2_r      <= 1'b0;
      v3_r      <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (clr_act) clr_r <= clr_r + CLR_W'(1);
      if (cfg_we) begin
        if (cfg_index == REG_LINE_THICKNESS) thick_r <= cfg_data[THK_W-1:0];
        if (cfg_index == REG_DIST_SHIFT) dshift_r <= cfg_data[DSH_W-1:0];
      end
      v1_r <= (state_r == ST_WALK) && inframe_c;
      v2_r <= v1_r || (accept && in_req_type == REQ_READ && rd_in_frame);
      v3_r <= v2_r;
      if (state_r == ST_FIN && (!out_valid || !out_stall)) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  // payload and request context
  always_ff @(posedge clk) begin
    addr1_r <= addr_c;
    dx1_r   <= dx_c;
    dy1_r   <= dy_c;
    rd2_r   <= !v1_r;
    addr2_r <= v1_r ? addr1_r : rd_addr;
    rd3_r   <= rd2_r;
    addr3_r <= addr2_r;
    sa3_r   <= sa_prod[15:8];

    if (accept) begin
      kind_r    <= in_req_type;
      red_r     <= in_red;
      green_r   <= in_green;
      blue_r    <= in_blue;
      alpha_r   <= in_alpha;
      layer_r   <= in_layer;
      t_r       <= tc;
      span_r    <= OFS_W'(2 * 32'(tc));
      ox_r      <= '0;
      oy_r      <= '0;
      i0_r      <= C_W'(px_c >>> 4) - C_W'(tc);
      j0_r      <= C_W'(py_c >>> 4) - C_W'(tc);
      pxlo_r    <= px_c[3:0];
      pylo_r    <= py_c[3:0];
      touched_r <= '0;
      res_r_r   <= '0;
      res_g_r   <= '0;
      res_b_r   <= '0;
    end else begin
      if (state_r == ST_WALK) begin
        // advance inner offset, wrap to next column
        if (oy_r == span_r) begin
          oy_r <= '0;
          ox_r <= ox_r + OFS_W'(1);
        end else begin
          oy_r <= oy_r + OFS_W'(1);
        end
        if (inframe_c && touched_r != '1) touched_r <= touched_r + CNT_W'(1);
      end
      if (bout.valid && bout.rd) begin
        res_r_r <= bout.pix[7:0];
        res_g_r <= bout.pix[15:8];
        res_b_r <= bout.pix[23:16];
      end
    end

    if (state_r == ST_FIN && (!out_valid || !out_stall)) begin
      out_done_kind      <= kind_r;
      out_red            <= res_r_r;
      out_green          <= res_g_r;
      out_blue           <= res_b_r;
      out_pixels_touched <= (kind_r == REQ_SPLAT) ? touched_r : '0;
    end
  end

endmodule

// File: hdl/gsf_ram.sv
// Simple dual-port synchronous RAM: one write port, one read port with
// registered read data. Self-contained.
`timescale 1ns / 1ps
module gsf_ram #(
  parameter int DATA_W = 32,
  parameter int DEPTH  = 256,
  parameter int AW     = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [AW-1:0]     raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: hdl/gsf_blend.sv
// Alpha-over blend: registered channel products, then a combinational divide by 255.
// Depends on gsf_pkg.
`timescale 1ns / 1ps
module gsf_blend (
  input  logic               clk,
  input  logic               rst_n,
  input  gsf_pkg::blend_in_t bin,
  output gsf_pkg::blend_out_t bout
);
  import gsf_pkg::*;

  logic              p_valid_r;
  logic              p_rd_r;
  logic [ADDR_W-1:0] p_addr_r;
  logic [16:0]       p_r_r, p_g_r, p_b_r;
  logic [16:0]       p_a_r;
  logic [7:0]        p_sa_r;
  logic [7:0]        inv;

  assign inv = 8'd255 - bin.sa;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r <= 1'b0;
    end else begin
      p_valid_r <= bin.valid;
    end
  end

  always_ff @(posedge clk) begin
    p_rd_r   <= bin.rd;
    p_addr_r <= bin.addr;
    p_sa_r   <= bin.sa;
    p_r_r    <= 17'(bin.src[7:0])   * 17'(bin.sa) + 17'(bin.dst[7:0])   * 17'(inv);
    p_g_r    <= 17'(bin.src[15:8])  * 17'(bin.sa) + 17'(bin.dst[15:8])  * 17'(inv);
    p_b_r    <= 17'(bin.src[23:16]) * 17'(bin.sa) + 17'(bin.dst[23:16]) * 17'(inv);
    p_a_r    <= 17'(bin.dst[31:24]) * 17'(inv);
  end

  always_comb begin
    bout.valid = p_valid_r;
    bout.rd    = p_rd_r;
    bout.addr  = p_addr_r;
    bout.pix   = {p_sa_r + div255(p_a_r), div255(p_b_r), div255(p_g_r), div255(p_r_r)};
  end

endmodule
